[hw/rtl/inpc_pkg.sv]
// Shared types and constants for the integer number property classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package inpc_pkg;

    localparam int IN_TDATA_BITS   = 16;
    localparam int OUT_TDATA_BITS  = 8;
    localparam int FLAG_COUNT      = 4;
    localparam int SPHENIC_FACTORS = 3;

    // Packed so that is_perfect lands in bit 0.
    typedef struct packed {
        logic is_sphenic;
        logic is_square;
        logic is_prime;
        logic is_perfect;
    } t_flags;

endpackage

`default_nettype wire

[hw/rtl/integer_number_property_classifier.sv]
// Top level of the integer number property classifier: trial division
// sequencer around one shared restoring divider. Depends on inpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one value per transfer and returns one transfer of four flags
// (perfect, prime, perfect square, sphenic). The block holds one value at a
// time: s_axis_tready is high only while the sequencer is idle, and a
// finished result sits in the output register until taken, so the next
// value can be accepted meanwhile. Each trial division runs on a single
// restoring divider that yields one quotient bit per cycle over a W-bit
// dividend, where W is the smaller of VALUE_BITS and 16. A zero value
// yields all flags clear.
module integer_number_property_classifier #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [inpc_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // [15:0] value
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [inpc_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata   // [0] is_perfect,
                                                                    // [1] is_prime,
                                                                    // [2] is_square,
                                                                    // [3] is_sphenic
);

    import inpc_pkg::*;

    localparam int W  = (VALUE_BITS < IN_TDATA_BITS) ? VALUE_BITS : IN_TDATA_BITS;
    localparam int QW = W + 2;   // square of trial divisor
    localparam int SW = W + 4;   // divisor sum
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] CNT_TOP  = CW'(W - 1);
    localparam logic [2:0]    DIST_SAT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK_A,
        ST_DIV_A,
        ST_EVAL_A,
        ST_CHECK_B,
        ST_DIV_B,
        ST_EVAL_B,
        ST_DONE
    } t_state;

    t_state          r_state,     n_state;
    logic            r_out_valid, n_out_valid;
    t_flags          r_flags,     n_flags;
    logic [W-1:0]    r_v,         n_v;
    logic [W-1:0]    r_n,         n_n;
    logic [W-1:0]    r_d,         n_d;
    logic [QW-1:0]   r_sq,        n_sq;
    logic [SW-1:0]   r_sum,       n_sum;
    logic [W-1:0]    r_rem,       n_rem;
    logic [W-1:0]    r_quo,       n_quo;
    logic [CW-1:0]   r_cnt,       n_cnt;
    logic [1:0]      r_mult,      n_mult;
    logic [2:0]      r_dist,      n_dist;
    logic            r_rep,       n_rep;
    logic            r_square,    n_square;

    logic [W:0]      div_t;
    logic [W:0]      div_diff;
    logic            div_ge;
    logic [QW-1:0]   sq_step;
    logic [2:0]      dist_inc;
    logic [W-1:0]    v_in;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS - FLAG_COUNT){1'b0}}, r_flags};

    assign v_in     = s_axis_tdata[W-1:0];
    assign div_t    = {r_rem, r_quo[W-1]};
    assign div_ge   = (div_t >= {1'b0, r_d});
    assign div_diff = div_t - {1'b0, r_d};
    assign sq_step  = r_sq + {1'b0, r_d, 1'b1};
    assign dist_inc = (r_dist == DIST_SAT) ? r_dist : r_dist + 3'd1;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_flags     = r_flags;
        n_v         = r_v;
        n_n         = r_n;
        n_d         = r_d;
        n_sq        = r_sq;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_mult      = r_mult;
        n_dist      = r_dist;
        n_rep       = r_rep;
        n_square    = r_square;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_v      = v_in;
                    n_n      = v_in;
                    n_d      = W'(1);
                    n_sq     = QW'(1);
                    n_sum    = '0;
                    n_mult   = '0;
                    n_dist   = '0;
                    n_rep    = 1'b0;
                    n_square = 1'b0;
                    n_state  = ST_CHECK_A;
                end
            end
            // divisor pairs (d, v/d) for d*d <= v
            ST_CHECK_A: begin
                if (r_sq <= {2'b00, r_v}) begin
                    if (r_sq == {2'b00, r_v}) begin
                        n_square = 1'b1;
                    end
                    n_rem   = '0;
                    n_quo   = r_v;
                    n_cnt   = CNT_TOP;
                    n_state = ST_DIV_A;
                end else begin
                    n_d     = W'(2);
                    n_sq    = QW'(4);
                    n_state = ST_CHECK_B;
                end
            end
            ST_DIV_A, ST_DIV_B: begin
                n_rem = div_ge ? div_diff[W-1:0] : div_t[W-1:0];
                n_quo = {r_quo[W-2:0], div_ge};
                if (r_cnt == '0) begin
                    n_state = (r_state == ST_DIV_A) ? ST_EVAL_A : ST_EVAL_B;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_EVAL_A: begin
                if (r_rem == '0) begin
                    n_sum = r_sum + SW'(r_d) + ((r_d != r_quo) ? SW'(r_quo) : SW'(0));
                end
                n_d     = r_d + 1'b1;
                n_sq    = sq_step;
                n_state = ST_CHECK_A;
            end
            // factorisation of n by trial division
            ST_CHECK_B: begin
                if (r_sq <= {2'b00, r_n}) begin
                    n_rem   = '0;
                    n_quo   = r_n;
                    n_cnt   = CNT_TOP;
                    n_state = ST_DIV_B;
                end else begin
                    if (r_n > W'(1)) begin
                        n_dist = dist_inc;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_EVAL_B: begin
                if (r_rem == '0) begin
                    n_n     = r_quo;
                    n_mult  = (r_mult == 2'd2) ? r_mult : r_mult + 2'd1;
                    n_rem   = '0;
                    n_quo   = r_quo;
                    n_cnt   = CNT_TOP;
                    n_state = ST_DIV_B;
                end else begin
                    if (r_mult != 2'd0) begin
                        n_dist = dist_inc;
                    end
                    if (r_mult > 2'd1) begin
                        n_rep = 1'b1;
                    end
                    n_mult  = '0;
                    n_d     = r_d + 1'b1;
                    n_sq    = sq_step;
                    n_state = ST_CHECK_B;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_flags.is_perfect = (r_v != '0) &&
                                         (r_sum == {3'b000, r_v, 1'b0});
                    n_flags.is_prime   = (r_v >= W'(2)) && (r_dist == 3'd1) &&
                                         !r_rep && (r_n == r_v);
                    n_flags.is_square  = r_square;
                    n_flags.is_sphenic = (r_dist == 3'(SPHENIC_FACTORS)) && !r_rep;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_flags  <= n_flags;
        r_v      <= n_v;
        r_n      <= n_n;
        r_d      <= n_d;
        r_sq     <= n_sq;
        r_sum    <= n_sum;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_mult   <= n_mult;
        r_dist   <= n_dist;
        r_rep    <= n_rep;
        r_square <= n_square;
    end

endmodule

`default_nettype wire

[hw/rtl/inpc_checker.sv]
// Port-level checker for the integer number property classifier, bound to
// the top level. Depends on inpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module inpc_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic [inpc_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [inpc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

    import inpc_pkg::*;

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one value in flight: busy after every input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after input transfer");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_BITS-1:FLAG_COUNT] == '0)
        else $error("padding bits set");

    // a prime is never perfect, square or sphenic
    a_prime_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |->
            !m_axis_tdata[0] && !m_axis_tdata[2] && !m_axis_tdata[3])
        else $error("prime flag with incompatible flag");

    a_sphenic_not_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[3]))
        else $error("sphenic and square together");

endmodule

bind integer_number_property_classifier inpc_checker u_inpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
